// ----- hw/rtl/segment_plane_intersection_top_defines.svh -----
// Assertion macros for the segment/plane intersection block.
// Used by the top level only; define ASSERT_OFF to drop all checks.
`ifndef SEGMENT_PLANE_INTERSECTION_TOP_DEFINES_SVH
`define SEGMENT_PLANE_INTERSECTION_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPI_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define SPI_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define SPI_ASSERT(lbl, prop)
`define SPI_NEVER(lbl, cond)
`endif
`endif

// ----- hw/rtl/spi_pkg.sv -----
// Shared types, codes, the division step function and a saturation helper for the segment/plane intersection block.
// No dependencies.
package spi_pkg;

	typedef logic signed [31:0] coord_t;
	typedef logic signed [32:0] diff_t;
	typedef logic signed [50:0] prod_t;
	typedef logic signed [52:0] acc_t;
	typedef logic [52:0] mag_t;

	localparam int unsigned TFRAC = 31;
	localparam int unsigned QDEPTH = 4;

	localparam logic [1:0] KIND_NONE      = 2'd0;
	localparam logic [1:0] KIND_TOUCH     = 2'd1;
	localparam logic [1:0] KIND_PENETRATE = 2'd2;

	localparam logic [2:0] REG_NORMAL_X = 3'd0;
	localparam logic [2:0] REG_NORMAL_Y = 3'd1;
	localparam logic [2:0] REG_NORMAL_Z = 3'd2;
	localparam logic [2:0] REG_ANCHOR_X = 3'd3;
	localparam logic [2:0] REG_ANCHOR_Y = 3'd4;
	localparam logic [2:0] REG_ANCHOR_Z = 3'd5;
	localparam logic [2:0] REG_TOL      = 3'd6;

	typedef enum logic [1:0] {
		CLS_NONE,
		CLS_START,
		CLS_END,
		CLS_DIV
	} cls_t;

	typedef struct packed {
		logic signed [17:0] nx;
		logic signed [17:0] ny;
		logic signed [17:0] nz;
		coord_t ax;
		coord_t ay;
		coord_t az;
		logic [15:0] tol;
	} cfg_t;

	// request handed from the classifier to the divider side
	typedef struct packed {
		cls_t cls;
		coord_t [2:0] s;
		diff_t [2:0] d;
		mag_t num;
		mag_t den;
	} mid_t;

	typedef struct packed {
		cls_t cls;
		coord_t [2:0] s;
		diff_t [2:0] d;
		mag_t r;
		mag_t den;
		logic [TFRAC-1:0] q;
	} dv_t;

	typedef struct packed {
		logic [1:0] kind;
		coord_t x;
		coord_t y;
		coord_t z;
	} out_t;

	// one restoring division step
	function automatic dv_t div_step(dv_t i);
		dv_t o;
		logic [53:0] r2;
		logic b;
		o = i;
		r2 = {i.r, 1'b0};
		b = (r2 >= {1'b0, i.den});
		if (b) begin
			o.r = 53'(r2 - {1'b0, i.den});
		end else begin
			o.r = r2[52:0];
		end
		o.q = {i.q[TFRAC-2:0], b};
		return o;
	endfunction

	function automatic coord_t sat32(logic signed [34:0] v);
		if (v > 35'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -35'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

endpackage

// ----- hw/rtl/segment_plane_intersection_top.sv -----
// Segment/plane intersection, top level: configuration registers and the two halves.
// Depends on spi_pkg, spi_front, spi_queue, spi_back and the assertion macro header.
//
// Segments enter through a queue-like port: push with start_* and end_* while full is
// low. Results leave the same way: while empty is low, hit_kind and hit_x/y/z show the
// oldest result; pop takes it. One result per segment, in order.
// Plane normal, anchor and tolerance are written on the cfg_* channel (index 0..6,
// other indexes ignored); cfg_ready is always high. Write only while the block is idle.
// A segment passes four front stages (differences, products, sums, classify), one
// queue slot, a load stage and 31 restoring-division stages, one multiply stage and
// the result queue. One segment per cycle is taken while no queue is full; the divider
// pipeline takes a new item every cycle while the result queue is not full.
// When pop stays low the result queue fills, the back pipeline holds, the middle queue
// fills and full rises; nothing is dropped.
// Reset clears all queues and pipeline valids and loads normal (0,0,1.0), anchor 0 and
// tolerance one LSB.
`include "segment_plane_intersection_top_defines.svh"
module segment_plane_intersection_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  spi_pkg::coord_t    start_x,
	input  spi_pkg::coord_t    start_y,
	input  spi_pkg::coord_t    start_z,
	input  spi_pkg::coord_t    end_x,
	input  spi_pkg::coord_t    end_y,
	input  spi_pkg::coord_t    end_z,
	output logic               empty,
	input  logic               pop,
	output logic [1:0]         hit_kind,
	output spi_pkg::coord_t    hit_x,
	output spi_pkg::coord_t    hit_y,
	output spi_pkg::coord_t    hit_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import spi_pkg::*;

	cfg_t cfg_q;
	coord_t start_pt [3], end_pt [3];
	logic mid_push, mid_full, mid_pop, mid_empty;
	mid_t mid_wdata, mid_rdata;
	out_t res;
	logic no_hit, hit_zero, kind_legal;

	assign cfg_ready = 1'b1;
	assign start_pt  = '{start_x, start_y, start_z};
	assign end_pt    = '{end_x, end_y, end_z};
	assign hit_kind  = res.kind;
	assign hit_x     = res.x;
	assign hit_y     = res.y;
	assign hit_z     = res.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{nx: '0, ny: '0, nz: 18'sd65536, ax: '0, ay: '0, az: '0, tol: 16'd1};
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_NORMAL_X: cfg_q.nx <= cfg_data[17:0];
				REG_NORMAL_Y: cfg_q.ny <= cfg_data[17:0];
				REG_NORMAL_Z: cfg_q.nz <= cfg_data[17:0];
				REG_ANCHOR_X: cfg_q.ax <= cfg_data;
				REG_ANCHOR_Y: cfg_q.ay <= cfg_data;
				REG_ANCHOR_Z: cfg_q.az <= cfg_data;
				REG_TOL:      cfg_q.tol <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	spi_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.start_pt (start_pt),
		.end_pt   (end_pt),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mid_full (mid_full)
	);

	spi_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (mid_push),
		.wdata   (mid_wdata),
		.q_full  (mid_full),
		.rd      (mid_pop),
		.rdata   (mid_rdata),
		.q_empty (mid_empty)
	);

	spi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (mid_rdata),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign no_hit     = !empty && hit_kind == KIND_NONE;
	assign hit_zero   = hit_x == '0 && hit_y == '0 && hit_z == '0;
	assign kind_legal = hit_kind == KIND_NONE || hit_kind == KIND_TOUCH
		|| hit_kind == KIND_PENETRATE;

	`SPI_NEVER(a_mid_full_empty, mid_full && mid_empty)
	`SPI_NEVER(a_mid_overflow, mid_push && mid_full)
	`SPI_ASSERT(a_nohit_zero, no_hit |-> hit_zero)
	`SPI_NEVER(a_bad_kind, !empty && !kind_legal)

endmodule

// ----- hw/rtl/spi_front.sv -----
// Front part: differences, dot products with the plane normal, classification.
// Depends on spi_pkg. Four stages, stalls as one when the middle queue is full and the last stage holds an item.
module spi_front (
	input  logic          clk,
	input  logic          arst_n,
	input  spi_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  spi_pkg::coord_t start_pt [3],
	input  spi_pkg::coord_t end_pt [3],
	output logic          mid_push,
	output spi_pkg::mid_t mid_data,
	input  logic          mid_full
);
	import spi_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	coord_t s_s1 [3], s_s2 [3], s_s3 [3];
	diff_t d_s1 [3], d_s2 [3], d_s3 [3];
	diff_t a_s1 [3];
	prod_t pd_s2 [3], pa_s2 [3];
	acc_t den_s3, dist_s3;
	mid_t item_s4;
	mid_t item_c;
	logic signed [17:0] nrm [3];
	coord_t anc [3];
	logic [52:0] tol_w, abs_den, abs_dist;
	logic signed [53:0] num_w;

	assign en       = !(v_s4 && mid_full);
	assign full     = !en;
	assign mid_push = v_s4 && !mid_full;
	assign mid_data = item_s4;
	assign nrm      = '{cfg.nx, cfg.ny, cfg.nz};
	assign anc      = '{cfg.ax, cfg.ay, cfg.az};

	always_comb begin
		tol_w    = {21'd0, cfg.tol, 16'd0};
		abs_den  = den_s3 < 0 ? 53'(-den_s3) : 53'(den_s3);
		abs_dist = dist_s3 < 0 ? 53'(-dist_s3) : 53'(dist_s3);
		num_w    = den_s3 < 0 ? 54'(dist_s3) : -54'(dist_s3);
		item_c.num = num_w[52:0];
		item_c.den = abs_den;
		for (int i = 0; i < 3; i++) begin
			item_c.s[i] = s_s3[i];
			item_c.d[i] = d_s3[i];
		end
		if (den_s3 == 0 || abs_den < tol_w) begin
			item_c.cls = (abs_dist <= tol_w) ? CLS_START : CLS_NONE;
		end else if (num_w < 0 || num_w[52:0] > abs_den) begin
			item_c.cls = CLS_NONE;
		end else if (num_w == 0) begin
			item_c.cls = CLS_START;
		end else if (num_w[52:0] == abs_den) begin
			item_c.cls = CLS_END;
		end else begin
			item_c.cls = CLS_DIV;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				s_s1[i]  <= start_pt[i];
				d_s1[i]  <= 33'(end_pt[i]) - 33'(start_pt[i]);
				a_s1[i]  <= 33'(start_pt[i]) - 33'(anc[i]);
				pd_s2[i] <= 51'(nrm[i]) * 51'(d_s1[i]);
				pa_s2[i] <= 51'(nrm[i]) * 51'(a_s1[i]);
				s_s2[i]  <= s_s1[i];
				d_s2[i]  <= d_s1[i];
				s_s3[i]  <= s_s2[i];
				d_s3[i]  <= d_s2[i];
			end
			den_s3  <= 53'(pd_s2[0]) + 53'(pd_s2[1]) + 53'(pd_s2[2]);
			dist_s3 <= 53'(pa_s2[0]) + 53'(pa_s2[1]) + 53'(pa_s2[2]);
			item_s4 <= item_c;
		end
	end

endmodule

// ----- hw/rtl/spi_queue.sv -----
// Short queue between the classifier and the divider side.
// Depends on spi_pkg.
module spi_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  spi_pkg::mid_t wdata,
	output logic          q_full,
	input  logic          rd,
	output spi_pkg::mid_t rdata,
	output logic          q_empty
);
	import spi_pkg::*;

	localparam int unsigned AW = $clog2(QDEPTH);

	mid_t mem [QDEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;

	assign q_full  = (cnt_q == (AW+1)'(QDEPTH));
	assign q_empty = (cnt_q == '0);
	assign rdata   = mem[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wp_q] <= wdata;
		end
	end

endmodule

// ----- hw/rtl/spi_back.sv -----
// Back part: pipelined restoring divider for t, point interpolation, result queue.
// Depends on spi_pkg. A load stage and 31 divider stages, one multiply stage, then the
// result queue.
module spi_back (
	input  logic          clk,
	input  logic          arst_n,
	input  spi_pkg::mid_t head,
	input  logic          mid_empty,
	output logic          mid_pop,
	output logic          empty,
	input  logic          pop,
	output spi_pkg::out_t res
);
	import spi_pkg::*;

	localparam int unsigned AW = $clog2(QDEPTH);

	typedef struct packed {
		cls_t cls;
		coord_t [2:0] s;
		diff_t [2:0] d;
		logic [2:0][63:0] prod;
	} ml_t;

	dv_t dv_q [TFRAC+1];
	logic dv_v_q [TFRAC+1];
	ml_t ml_q;
	logic ml_v_q;
	out_t fin;
	out_t oq_mem [QDEPTH];
	logic [AW-1:0] owp_q, orp_q;
	logic [AW:0] ocnt_q;
	logic of_full, en, opush, opop;
	logic [63:0] rsum [3];
	logic signed [34:0] pt [3];
	coord_t ps [3];

	assign of_full = (ocnt_q == (AW+1)'(QDEPTH));
	assign en      = !(ml_v_q && of_full);
	assign mid_pop = en && !mid_empty;
	assign opush   = ml_v_q && !of_full;
	assign empty   = (ocnt_q == '0);
	assign opop    = pop && !empty;
	assign res     = oq_mem[orp_q];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = ml_q.prod[i] + 64'h4000_0000;
			if (ml_q.d[i][32]) begin
				pt[i] = 35'($signed(ml_q.s[i])) - 35'({1'b0, rsum[i][63:TFRAC]});
			end else begin
				pt[i] = 35'($signed(ml_q.s[i])) + 35'({1'b0, rsum[i][63:TFRAC]});
			end
			ps[i] = sat32(pt[i]);
		end
		case (ml_q.cls)
			CLS_START: fin = '{kind: KIND_TOUCH, x: ml_q.s[0], y: ml_q.s[1], z: ml_q.s[2]};
			CLS_END: fin = '{kind: KIND_TOUCH,
				x: ml_q.s[0] + ml_q.d[0][31:0],
				y: ml_q.s[1] + ml_q.d[1][31:0],
				z: ml_q.s[2] + ml_q.d[2][31:0]};
			CLS_DIV: fin = '{kind: KIND_PENETRATE, x: ps[0], y: ps[1], z: ps[2]};
			default: fin = '{kind: KIND_NONE, x: '0, y: '0, z: '0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= TFRAC; k++) begin
				dv_v_q[k] <= 1'b0;
			end
			ml_v_q <= 1'b0;
			owp_q  <= '0;
			orp_q  <= '0;
			ocnt_q <= '0;
		end else begin
			if (en) begin
				dv_v_q[0] <= mid_pop;
				for (int k = 0; k < TFRAC; k++) begin
					dv_v_q[k+1] <= dv_v_q[k];
				end
				ml_v_q <= dv_v_q[TFRAC];
			end
			if (opush) begin
				owp_q <= owp_q + 1'b1;
			end
			if (opop) begin
				orp_q <= orp_q + 1'b1;
			end
			ocnt_q <= ocnt_q + (AW+1)'(opush) - (AW+1)'(opop);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_q[0] <= '{cls: head.cls, s: head.s, d: head.d, r: head.num,
				den: head.den, q: '0};
			for (int k = 0; k < TFRAC; k++) begin
				dv_q[k+1] <= div_step(dv_q[k]);
			end
			ml_q.cls <= dv_q[TFRAC].cls;
			ml_q.s   <= dv_q[TFRAC].s;
			ml_q.d   <= dv_q[TFRAC].d;
			for (int i = 0; i < 3; i++) begin
				ml_q.prod[i] <= 64'(dv_q[TFRAC].d[i][32] ? 33'(-dv_q[TFRAC].d[i])
					: dv_q[TFRAC].d[i]) * 64'(dv_q[TFRAC].q);
			end
		end
		if (opush) begin
			oq_mem[owp_q] <= fin;
		end
	end

endmodule
